// ===== rtl/stunap_pkg.sv =====
// Shared types and constants for the STUN response address parser.
package stunap_pkg;

  localparam int DEFAULT_MAX_ATTR_WORDS = 16;

  localparam int HDR_IDX_W   = 3;
  localparam int BYTES_W     = 17;
  localparam int CNT_W       = 14;
  localparam int TDATA_OUT_W = 104;
  localparam int PADDR_W     = 3;

  localparam logic [HDR_IDX_W-1:0] HDR_WORDS = 3'd5;
  localparam logic [BYTES_W-1:0]   BYTES_MAX = 17'h1FFFF;

  localparam logic [15:0] MSG_BINDING_RESP  = 16'h0101;
  localparam logic [15:0] ATTR_MAPPED       = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED   = 16'h8020;
  localparam logic [15:0] ATTR_XOR_MAPPED_0 = 16'h0020;
  localparam logic [15:0] ATTR_CHANGED      = 16'h0005;
  localparam logic [15:0] ATTR_ERROR_CODE   = 16'h0009;
  localparam logic [15:0] FAMILY_IPV4       = 16'h0001;

  localparam logic [PADDR_W-1:0] ADDR_COOKIE = 3'd0;

  // Value word position inside an attribute; saturates at VIDX_REST.
  typedef enum logic [1:0] {
    VIDX_PORT = 2'd0,
    VIDX_IP   = 2'd1,
    VIDX_REST = 2'd2
  } vidx_t;

  typedef struct packed {
    logic        malformed;
    logic        server_error;
    logic [15:0] changed_port;
    logic [31:0] changed_ip;
    logic [15:0] mapped_port;
    logic [31:0] mapped_ip;
    logic        ok;
  } res_t;

endpackage

// ===== rtl/stunap_parse.sv =====
// Per-beat parse state of the STUN header and attribute walk.
module stunap_parse #(
  parameter int MAX_ATTR_WORDS = stunap_pkg::DEFAULT_MAX_ATTR_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [31:0]       word,
  input  logic              last,
  input  logic [31:0]       cookie,
  output logic              res_valid,
  output stunap_pkg::res_t  res
);
  import stunap_pkg::*;

  localparam int WL_W = $clog2(MAX_ATTR_WORDS + 1);

  logic [HDR_IDX_W-1:0] hdr_idx, hdr_idx_next;
  logic [15:0]          hdr_len, hdr_len_next;
  logic                 type_good, type_good_next;
  logic [BYTES_W-1:0]   bytes_seen, bytes_seen_next;
  logic [15:0]          code, code_next;
  logic [WL_W-1:0]      words_left, words_left_next;
  vidx_t                vidx, vidx_next;
  logic [15:0]          map_port, map_port_next;
  logic [31:0]          map_ip, map_ip_next;
  logic [15:0]          chg_port, chg_port_next;
  logic [31:0]          chg_ip, chg_ip_next;
  logic                 srv_err, srv_err_next;
  logic                 malformed, malformed_next;

  logic [CNT_W-1:0] cnt;
  logic             bad_len;
  logic             is_v4;
  logic [BYTES_W:0] bytes_sum;
  logic             short_pkt;

  assign cnt       = word[15:2];
  assign bad_len   = (word[1:0] != 2'b00) || (cnt > CNT_W'(MAX_ATTR_WORDS));
  assign is_v4     = word[31:16] == FAMILY_IPV4;
  assign bytes_sum = {1'b0, bytes_seen} + (BYTES_W+1)'(4);

  always_comb begin
    hdr_idx_next    = hdr_idx;
    hdr_len_next    = hdr_len;
    type_good_next  = type_good;
    bytes_seen_next = bytes_seen;
    code_next       = code;
    words_left_next = words_left;
    vidx_next       = vidx;
    map_port_next   = map_port;
    map_ip_next     = map_ip;
    chg_port_next   = chg_port;
    chg_ip_next     = chg_ip;
    srv_err_next    = srv_err;
    malformed_next  = malformed;
    if (hdr_idx < HDR_WORDS) begin
      if (hdr_idx == '0) begin
        type_good_next = word[31:16] == MSG_BINDING_RESP;
        hdr_len_next   = word[15:0];
      end
      hdr_idx_next = hdr_idx + HDR_IDX_W'(1);
    end else begin
      bytes_seen_next = bytes_sum[BYTES_W] ? BYTES_MAX : bytes_sum[BYTES_W-1:0];
      if (!malformed) begin
        if (words_left == '0) begin
          if (bad_len) begin
            malformed_next = 1'b1;
          end else begin
            code_next       = word[31:16];
            words_left_next = WL_W'(cnt);
            vidx_next       = VIDX_PORT;
          end
        end else begin
          unique case (code)
            ATTR_MAPPED: begin
              if (vidx == VIDX_PORT && is_v4) map_port_next = word[15:0];
              else if (vidx == VIDX_IP)       map_ip_next   = word;
            end
            ATTR_XOR_MAPPED, ATTR_XOR_MAPPED_0: begin
              if (vidx == VIDX_PORT && is_v4) map_port_next = word[15:0] ^ cookie[31:16];
              else if (vidx == VIDX_IP)       map_ip_next   = word ^ cookie;
            end
            ATTR_CHANGED: begin
              if (vidx == VIDX_PORT && is_v4) chg_port_next = word[15:0];
              else if (vidx == VIDX_IP)       chg_ip_next   = word;
            end
            ATTR_ERROR_CODE: begin
              srv_err_next = 1'b1;
            end
            default: begin
            end
          endcase
          unique case (vidx)
            VIDX_PORT: vidx_next = VIDX_IP;
            default:   vidx_next = VIDX_REST;
          endcase
          words_left_next = words_left - WL_W'(1);
        end
      end
    end
  end

  // The result sees the state as updated by the final beat.
  always_comb begin
    short_pkt        = hdr_idx_next < HDR_WORDS;
    res.ok           = !short_pkt && type_good_next &&
                       (bytes_seen_next == {1'b0, hdr_len_next});
    res.mapped_ip    = res.ok ? map_ip_next   : '0;
    res.mapped_port  = res.ok ? map_port_next : '0;
    res.changed_ip   = res.ok ? chg_ip_next   : '0;
    res.changed_port = res.ok ? chg_port_next : '0;
    res.server_error = srv_err_next;
    res.malformed    = malformed_next || short_pkt || (words_left_next != '0);
    res_valid        = beat && last;
  end

  always_ff @(posedge clk) begin
    if (rst || (beat && last)) begin
      hdr_idx    <= '0;
      hdr_len    <= '0;
      type_good  <= 1'b0;
      bytes_seen <= '0;
      code       <= '0;
      words_left <= '0;
      vidx       <= VIDX_PORT;
      map_port   <= '0;
      map_ip     <= '0;
      chg_port   <= '0;
      chg_ip     <= '0;
      srv_err    <= 1'b0;
      malformed  <= 1'b0;
    end else if (beat) begin
      hdr_idx    <= hdr_idx_next;
      hdr_len    <= hdr_len_next;
      type_good  <= type_good_next;
      bytes_seen <= bytes_seen_next;
      code       <= code_next;
      words_left <= words_left_next;
      vidx       <= vidx_next;
      map_port   <= map_port_next;
      map_ip     <= map_ip_next;
      chg_port   <= chg_port_next;
      chg_ip     <= chg_ip_next;
      srv_err    <= srv_err_next;
      malformed  <= malformed_next;
    end
  end

endmodule

// ===== rtl/stunap_out.sv =====
// Result register that holds one finished result until the sink takes it.
module stunap_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 res_valid,
  input  stunap_pkg::res_t                     res,
  output logic                                 in_ready,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [stunap_pkg::TDATA_OUT_W-1:0]   m_tdata
);
  import stunap_pkg::*;

  res_t held;

  // Free when empty or when the waiting result leaves this cycle.
  assign in_ready = !m_tvalid || m_tready;
  assign m_tdata  = {(TDATA_OUT_W - $bits(res_t))'(0), held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

endmodule

// ===== rtl/stun_response_address_parser_top.sv =====
// Top level of the STUN binding-response address parser.
// The result appears on m_tvalid in the cycle after the beat with tlast is taken.
// Throughput: one word beat per cycle; s_tready drops only while a result waits on m_tready.
// The attribute walk is a single state update per beat, so any packet length streams at full rate.
// Reset (rst, synchronous, active high) clears the cookie, the parse state and the result valid.
module stun_response_address_parser_top #(
  parameter int MAX_ATTR_WORDS = stunap_pkg::DEFAULT_MAX_ATTR_WORDS
) (
  input  logic                                clk,
  input  logic                                rst,
  // Input stream: one 32-bit packet word per beat, wire byte order.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,  // [31:0] word
  input  logic                                s_tlast,
  // Result stream: one beat per packet.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] ok, [32:1] mapped_ip, [48:33] mapped_port, [80:49] changed_ip,
  // [96:81] changed_port, [97] server_error, [98] malformed, [103:99] zero
  output logic [stunap_pkg::TDATA_OUT_W-1:0]  m_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stunap_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import stunap_pkg::*;

  logic [31:0] cookie;
  logic        beat;
  logic        res_valid;
  res_t        res;

  // The cookie register is the only register; writes elsewhere are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_COOKIE) ? cookie : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cookie <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_COOKIE) begin
      cookie <= pwdata;
    end
  end

  // A word beat moves whenever the result register can take whatever it might produce.
  assign beat = s_tvalid && s_tready;

  stunap_parse #(
    .MAX_ATTR_WORDS (MAX_ATTR_WORDS)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat),
    .word      (s_tdata),
    .last      (s_tlast),
    .cookie    (cookie),
    .res_valid (res_valid),
    .res       (res)
  );

  stunap_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .in_ready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // The final beat of a packet always leaves a result waiting next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("final beat produced no result");

  // A beat that is not the final one never starts a new result.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tlast) |=> !$rose(m_tvalid))
    else $error("result raised without a final beat");

  // A failed header check reports no address or port.
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[96:1] == '0))
    else $error("address fields set on a failed packet");

endmodule

// ===== sim/stun_response_address_parser_top_tb.sv =====
// Self-checking testbench for the STUN response address parser top level.
`timescale 1ns / 1ps

// Tracks the parse of the current packet and holds the results still to come.
class stun_response_predictor;
  int unsigned        max_words;
  logic [31:0]        cookie;
  logic [2:0]         hdr_words;
  logic [15:0]        hdr_len;
  logic               type_good;
  logic [16:0]        body_bytes;
  logic [15:0]        attr_code;
  logic [13:0]        words_left;
  logic [13:0]        value_idx;
  logic [47:0]        mapped_addr;
  logic [47:0]        changed_addr;
  logic               server_error;
  logic               malformed;
  stunap_pkg::res_t   expected_results[$];
  int unsigned        mismatches;

  function new(int unsigned max_attr_words);
    max_words  = max_attr_words;
    cookie     = '0;
    mismatches = 0;
    clear_packet();
  endfunction

  function void clear_packet();
    hdr_words    = '0;
    hdr_len      = '0;
    type_good    = 1'b0;
    body_bytes   = '0;
    attr_code    = '0;
    words_left   = '0;
    value_idx    = '0;
    mapped_addr  = '0;
    changed_addr = '0;
    server_error = 1'b0;
    malformed    = 1'b0;
  endfunction

  function void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Called for every accepted word beat.
  function void note_word(logic [31:0] w, logic last);
    logic [17:0]      sum;
    logic [15:0]      len;
    logic             port_ok;
    logic             short_pkt;
    stunap_pkg::res_t r;
    if (hdr_words < stunap_pkg::HDR_WORDS) begin
      if (hdr_words == 0) begin
        type_good = (w[31:16] == stunap_pkg::MSG_BINDING_RESP);
        hdr_len   = w[15:0];
      end
      hdr_words++;
    end else begin
      sum        = {1'b0, body_bytes} + 18'd4;
      body_bytes = (sum > {1'b0, stunap_pkg::BYTES_MAX}) ? stunap_pkg::BYTES_MAX : sum[16:0];
      if (!malformed) begin
        if (words_left == 0) begin
          len = w[15:0];
          if (len[1:0] != 2'b00 || len[15:2] > max_words) begin
            malformed = 1'b1;
          end else begin
            attr_code  = w[31:16];
            words_left = len[15:2];
            value_idx  = '0;
          end
        end else begin
          port_ok = (value_idx == 0) && (w[31:16] == stunap_pkg::FAMILY_IPV4);
          case (attr_code)
            stunap_pkg::ATTR_MAPPED: begin
              if (port_ok) mapped_addr[47:32] = w[15:0];
              else if (value_idx == 1) mapped_addr[31:0] = w;
            end
            stunap_pkg::ATTR_XOR_MAPPED, stunap_pkg::ATTR_XOR_MAPPED_0: begin
              if (port_ok) mapped_addr[47:32] = w[15:0] ^ cookie[31:16];
              else if (value_idx == 1) mapped_addr[31:0] = w ^ cookie;
            end
            stunap_pkg::ATTR_CHANGED: begin
              if (port_ok) changed_addr[47:32] = w[15:0];
              else if (value_idx == 1) changed_addr[31:0] = w;
            end
            stunap_pkg::ATTR_ERROR_CODE: server_error = 1'b1;
            default: ;
          endcase
          value_idx++;
          words_left--;
        end
      end
    end
    if (last) begin
      short_pkt = hdr_words < stunap_pkg::HDR_WORDS;
      r         = '0;
      r.ok      = !short_pkt && type_good && (body_bytes == {1'b0, hdr_len});
      if (r.ok) begin
        r.mapped_ip    = mapped_addr[31:0];
        r.mapped_port  = mapped_addr[47:32];
        r.changed_ip   = changed_addr[31:0];
        r.changed_port = changed_addr[47:32];
      end
      r.server_error = server_error;
      r.malformed    = malformed || short_pkt || (words_left != 0);
      expected_results.push_back(r);
      clear_packet();
    end
  endfunction

  // Called for every accepted result beat.
  function void check_result(logic [stunap_pkg::TDATA_OUT_W-1:0] beat);
    stunap_pkg::res_t got;
    stunap_pkg::res_t want;
    got = beat[$bits(stunap_pkg::res_t)-1:0];
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result beat %0h with none expected", $time, beat);
      return;
    end
    want = expected_results.pop_front();
    compare_field("ok", want.ok, got.ok);
    compare_field("mapped_ip", want.mapped_ip, got.mapped_ip);
    compare_field("mapped_port", want.mapped_port, got.mapped_port);
    compare_field("changed_ip", want.changed_ip, got.changed_ip);
    compare_field("changed_port", want.changed_port, got.changed_port);
    compare_field("server_error", want.server_error, got.server_error);
    compare_field("malformed", want.malformed, got.malformed);
    compare_field("padding", '0, beat[stunap_pkg::TDATA_OUT_W-1:$bits(stunap_pkg::res_t)]);
  endfunction
endclass

module stun_response_address_parser_top_tb;
  import stunap_pkg::*;

  localparam int ATTR_WORDS_MAX  = DEFAULT_MAX_ATTR_WORDS;
  // The result waits on m_tvalid from the cycle after the last word; wait a little longer to be safe.
  localparam int RESULT_LATENCY  = 1;
  localparam int PHASE_WORDS     = 470;

  // Ways in which a random packet is damaged.
  typedef enum int {
    FAULT_NONE,
    FAULT_TYPE,
    FAULT_LENGTH,
    FAULT_ATTR_LEN,
    FAULT_TRUNCATE,
    FAULT_SHORT,
    FAULT_NOISE
  } fault_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [31:0]            s_tdata;   // [31:0] word
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready;
  // [0] ok, [32:1] mapped_ip, [48:33] mapped_port, [80:49] changed_ip,
  // [96:81] changed_port, [97] server_error, [98] malformed, [103:99] zero
  logic [TDATA_OUT_W-1:0] m_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  stun_response_predictor parse_model;
  int unsigned            send_idle_pct;
  int unsigned            recv_idle_pct;
  int unsigned            words_sent;
  logic [31:0]            pkt_words[$];

  stun_response_address_parser_top #(
    .MAX_ATTR_WORDS(ATTR_WORDS_MAX)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides at every falling edge whether it takes a result beat
  // in the next cycle, so stalls land on every phase of the parse.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result beat is checked at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) parse_model.check_result(m_tdata);
  end

  // Sends the words in pkt_words as one packet, with tlast on the final beat.
  // The sender may idle before any beat; tvalid stays high across
  // back-to-back beats. Entered and left at a falling edge.
  task automatic send_packet();
    for (int i = 0; i < pkt_words.size(); i++) begin
      while ($urandom_range(99) < send_idle_pct) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
      s_tvalid = 1'b1;
      s_tdata  = pkt_words[i];
      s_tlast  = (i == pkt_words.size() - 1);
      do @(posedge clk); while (!s_tready);
      parse_model.note_word(s_tdata, s_tlast);
      @(negedge clk);
    end
    words_sent += pkt_words.size();
  endtask

  // Holds the sender off until every expected result beat has arrived, then
  // lets the result latency pass so the block is surely idle.
  task automatic drain();
    s_tvalid = 1'b0;
    while (parse_model.expected_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 1) @(posedge clk);
    @(negedge clk);
  endtask

  // A setup and an access cycle write the register; a read of the same
  // address follows and must return the written value.
  task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    parse_model.compare_field("cookie readback", value, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (addr == ADDR_COOKIE) parse_model.cookie = value;
  endtask

  // Appends one attribute of n value words. The first value word mostly
  // carries the IPv4 family so that the port gets decoded.
  task automatic add_attribute(input logic [15:0] code, input int unsigned n);
    pkt_words.push_back({code, 14'(n), 2'b00});
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(9) < 8) pkt_words.push_back({FAMILY_IPV4, 16'($urandom)});
      else pkt_words.push_back($urandom);
    end
  endtask

  // Most packets are well-formed responses with random attributes; about
  // three in ten are damaged in one of the ways listed in fault_t.
  task automatic build_random_packet();
    int unsigned n_attrs;
    int unsigned n_words;
    int unsigned keep;
    int unsigned pick;
    logic [15:0] code;
    fault_t      fault;
    pkt_words.delete();
    pkt_words.push_back('0);
    repeat (4) pkt_words.push_back($urandom);
    n_attrs = $urandom_range(4);
    for (int a = 0; a < n_attrs; a++) begin
      case ($urandom_range(5))
        0:       code = ATTR_MAPPED;
        1:       code = ATTR_XOR_MAPPED;
        2:       code = ATTR_XOR_MAPPED_0;
        3:       code = ATTR_CHANGED;
        4:       code = ATTR_ERROR_CODE;
        default: code = 16'($urandom);
      endcase
      pick = $urandom_range(99);
      if (pick < 65)      n_words = 2;
      else if (pick < 80) n_words = $urandom_range(1);
      else                n_words = $urandom_range(ATTR_WORDS_MAX, 3);
      add_attribute(code, n_words);
    end
    fault = FAULT_NONE;
    if ($urandom_range(99) < 30) fault = fault_t'($urandom_range(FAULT_NOISE, FAULT_TYPE));
    // A bad attribute length stops the walk, but the header length still
    // counts the words behind it.
    if (fault == FAULT_ATTR_LEN) begin
      if ($urandom_range(1)) pkt_words.push_back({16'($urandom), 14'($urandom),
                                                  2'($urandom_range(3, 1))});
      else pkt_words.push_back({16'($urandom),
                                14'($urandom_range(16383, ATTR_WORDS_MAX + 1)), 2'b00});
      repeat ($urandom_range(3)) pkt_words.push_back($urandom);
    end
    pkt_words[0] = {MSG_BINDING_RESP, 16'((pkt_words.size() - 5) * 4)};
    case (fault)
      FAULT_TYPE:   pkt_words[0][31:16] = MSG_BINDING_RESP ^ 16'($urandom_range(65535, 1));
      FAULT_LENGTH: pkt_words[0][15:0]  = pkt_words[0][15:0] ^ 16'($urandom_range(65535, 1));
      FAULT_TRUNCATE: begin
        keep = $urandom_range(pkt_words.size() - 1, 1);
        while (pkt_words.size() > keep) void'(pkt_words.pop_back());
      end
      FAULT_SHORT: begin
        keep = $urandom_range(4, 1);
        if ($urandom_range(1)) pkt_words[0] = $urandom;
        while (pkt_words.size() > keep) void'(pkt_words.pop_back());
      end
      FAULT_NOISE:  repeat ($urandom_range(3, 1)) pkt_words.push_back($urandom);
      default: ;
    endcase
  endtask

  // One random phase: wait for an idle block, set the cookie, set the idle
  // rates, and stream random packets until the word goal is met.
  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input logic [31:0] key, input int unsigned word_goal);
    int unsigned start;
    drain();
    write_register(ADDR_COOKIE, key);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    start         = words_sent;
    while (words_sent - start < word_goal) begin
      build_random_packet();
      send_packet();
    end
  endtask

  initial begin
    parse_model   = new(ATTR_WORDS_MAX);
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    words_sent    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed packets, sent back to back with a typical STUN magic cookie.
    write_register(ADDR_COOKIE, 32'h2112_A442);
    // A packet that ends on its first word is short and therefore malformed.
    pkt_words = '{32'hFFFF_FFFF};
    send_packet();
    // A bare header with zero length is a valid, empty response.
    pkt_words = '{32'h0101_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
    send_packet();
    // Mapped address at its extremes, then overwritten by the XOR form; a
    // changed address of another family keeps its port at zero but takes
    // the address; an error code sets its flag.
    pkt_words = '{
      {MSG_BINDING_RESP, 16'd44}, 32'h2112_A442, 32'h0123_4567, 32'h89AB_CDEF, 32'h5A5A_A5A5,
      {ATTR_MAPPED, 16'd8}, {FAMILY_IPV4, 16'hFFFF}, 32'hFFFF_FFFF,
      {ATTR_XOR_MAPPED_0, 16'd8}, {FAMILY_IPV4, 16'h0000}, 32'h0000_0000,
      {ATTR_CHANGED, 16'd8}, {16'h0002, 16'h1234}, 32'hC0A8_0001,
      {ATTR_ERROR_CODE, 16'd4}, 32'h0000_0401
    };
    send_packet();
    // An attribute length that is not a multiple of four.
    pkt_words = '{{MSG_BINDING_RESP, 16'd4}, 32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
    send_packet();

    // Random phases: the sender idles less than the receiver, then the
    // reverse, then neither idles. Each phase boundary holds the sender
    // until all expected results are in, and changes the cookie.
    run_phase(14, 48, 32'h0000_0000, PHASE_WORDS);
    run_phase(48, 14, 32'hFFFF_FFFF, PHASE_WORDS);
    run_phase(0, 0, $urandom, PHASE_WORDS);

    drain();
    if (parse_model.mismatches == 0 && parse_model.expected_results.size() == 0) begin
      $display("stun_response_address_parser_top verification clean");
    end else begin
      $display("stun_response_address_parser_top verification failed");
    end
    $finish;
  end

  // Run limit: the whole run takes well under a tenth of this.
  initial begin
    #20_000_000;
    $display("stun_response_address_parser_top verification failed");
    $finish;
  end

endmodule
